// ----- rtl/core/kvmap_pkg.sv -----
`timescale 1ns / 1ps

package kvmap_pkg;

	// Table geometry.
	localparam int ENTRIES = 16;
	localparam int WORD_W  = 64;
	localparam int WORDS   = 4;
	localparam int KEY_W   = WORD_W * WORDS;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int COUNT_W = $clog2(ENTRIES + 1);
	localparam int USED_W  = 5;
	localparam int STAT_W  = 2;

	// Command codes.
	localparam logic CMD_SET = 1'b0;
	localparam logic CMD_GET = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef logic [KEY_W-1:0] kvmap_line_t;

endpackage

// ----- rtl/core/fixed_capacity_key_value_map_unit.sv -----
`timescale 1ns / 1ps
// A search walks the stored entries in order and stops at the first match; a miss compares
// against every stored entry, and on an empty table the search is skipped.
// Items are taken one at a time, and the pace of each is set by the single key comparator,
// which walks the key RAM one entry per cycle.
// Reset clears the entry count and all control state; the key and value RAMs are not
// cleared, since only entries below the count are ever read.

module fixed_capacity_key_value_map_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  cmd,
	input  logic [kvmap_pkg::WORD_W-1:0]          key_word0,
	input  logic [kvmap_pkg::WORD_W-1:0]          key_word1,
	input  logic [kvmap_pkg::WORD_W-1:0]          key_word2,
	input  logic [kvmap_pkg::WORD_W-1:0]          key_word3,
	input  logic [kvmap_pkg::WORD_W-1:0]          value_word0,
	input  logic [kvmap_pkg::WORD_W-1:0]          value_word1,
	input  logic [kvmap_pkg::WORD_W-1:0]          value_word2,
	input  logic [kvmap_pkg::WORD_W-1:0]          value_word3,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic [kvmap_pkg::STAT_W-1:0]          status,
	output logic [kvmap_pkg::WORD_W-1:0]          read_word0,
	output logic [kvmap_pkg::WORD_W-1:0]          read_word1,
	output logic [kvmap_pkg::WORD_W-1:0]          read_word2,
	output logic [kvmap_pkg::WORD_W-1:0]          read_word3,
	output logic [kvmap_pkg::USED_W-1:0]          used_entries
);

	localparam int W  = kvmap_pkg::WORD_W;
	localparam int CW = kvmap_pkg::COUNT_W;
	localparam int IW = kvmap_pkg::IDX_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_ACT    = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]                      state_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   rd_idx_q;
	logic [CW-1:0]                   cmp_idx_s1;
	logic                            pend_s1;
	logic                            hit_q;
	logic [IW-1:0]                   hit_idx_q;
	logic                            cmd_q;
	kvmap_pkg::kvmap_line_t          key_q;
	kvmap_pkg::kvmap_line_t          val_q;
	logic [kvmap_pkg::STAT_W-1:0]    res_st_q;

	logic                            rsp_valid_q;
	logic [kvmap_pkg::STAT_W-1:0]    status_q;
	kvmap_pkg::kvmap_line_t          read_q;
	logic [kvmap_pkg::USED_W-1:0]    used_q;

	logic                            accept;
	logic                            issue;
	logic                            key_match;
	logic                            last_cmp;
	logic                            full;
	logic                            act_update;
	logic                            act_append;
	logic                            act_get_hit;
	logic                            out_free;
	kvmap_pkg::kvmap_line_t          key_rdata;
	kvmap_pkg::kvmap_line_t          val_rdata;
	logic [IW-1:0]                   val_waddr;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	// One key read is issued per cycle; the compare runs in the cycle after the read is issued.
	assign issue     = (state_q == S_SEARCH) && (rd_idx_q < count_q);
	assign key_match = pend_s1 && (key_rdata == key_q);
	assign last_cmp  = pend_s1 && ((cmp_idx_s1 + CW'(1)) == count_q);
	assign full      = (count_q == CW'(kvmap_pkg::ENTRIES));

	assign act_update  = (state_q == S_ACT) && (cmd_q == kvmap_pkg::CMD_SET) && hit_q;
	assign act_append  = (state_q == S_ACT) && (cmd_q == kvmap_pkg::CMD_SET) && !hit_q
		&& !full;
	assign act_get_hit = (state_q == S_ACT) && (cmd_q == kvmap_pkg::CMD_GET) && hit_q;
	assign val_waddr   = hit_q ? hit_idx_q : count_q[IW-1:0];
	assign out_free    = !rsp_valid_q || !rsp_stall;

	kvmap_ram #(
		.WIDTH(kvmap_pkg::KEY_W),
		.DEPTH(kvmap_pkg::ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (act_append),
		.waddr (count_q[IW-1:0]),
		.wdata (key_q),
		.re    (issue),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (key_rdata)
	);

	kvmap_ram #(
		.WIDTH(kvmap_pkg::KEY_W),
		.DEPTH(kvmap_pkg::ENTRIES)
	) u_val_ram (
		.clk   (clk),
		.we    (act_update || act_append),
		.waddr (val_waddr),
		.wdata (val_q),
		.re    (act_get_hit),
		.raddr (hit_idx_q),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= {key_word3, key_word2, key_word1, key_word0};
			val_q <= {value_word3, value_word2, value_word1, value_word0};
		end
		if (issue) begin
			cmp_idx_s1 <= rd_idx_q;
		end
		if (key_match && (state_q == S_SEARCH)) begin
			hit_idx_q <= cmp_idx_s1[IW-1:0];
		end
		if (state_q == S_ACT) begin
			if (cmd_q == kvmap_pkg::CMD_SET) begin
				res_st_q <= (!hit_q && full) ? kvmap_pkg::ST_FULL : kvmap_pkg::ST_OK;
			end else begin
				res_st_q <= hit_q ? kvmap_pkg::ST_OK : kvmap_pkg::ST_NOT_FOUND;
			end
		end
		if ((state_q == S_FINISH) && out_free) begin
			status_q <= res_st_q;
			used_q   <= kvmap_pkg::USED_W'(count_q);
			// The value RAM output still holds the word read in the action cycle.
			if ((cmd_q == kvmap_pkg::CMD_GET) && hit_q) begin
				read_q <= val_rdata;
			end else begin
				read_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FINISH) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						hit_q    <= 1'b0;
						rd_idx_q <= '0;
						state_q  <= (count_q == '0) ? S_ACT : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					pend_s1 <= issue && !(key_match || last_cmp);
					if (key_match) begin
						hit_q   <= 1'b1;
						state_q <= S_ACT;
					end else if (last_cmp) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					pend_s1 <= 1'b0;
					if (act_append) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign read_word0   = read_q[W-1:0];
	assign read_word1   = read_q[2*W-1:W];
	assign read_word2   = read_q[3*W-1:2*W];
	assign read_word3   = read_q[4*W-1:3*W];
	assign used_entries = used_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(kvmap_pkg::ENTRIES))
		else $error("entry count exceeds table capacity");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q == kvmap_pkg::ST_FULL)) |-> full)
		else $error("full status reported with free entries");

	a_pend_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_SEARCH))
		else $error("compare pending outside of search");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ACT) && hit_q) |-> (CW'(hit_idx_q) < count_q))
		else $error("hit index beyond stored entries");

	a_no_append_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		act_update |=> (count_q == $past(count_q)))
		else $error("entry count changed on an update");

endmodule

// ----- rtl/core/kvmap_ram.sv -----
`timescale 1ns / 1ps

module kvmap_ram #(
	parameter int WIDTH = 256,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
